@@ hw/rtl/stig_pkg.sv @@
package stig_pkg;

  localparam int ValueW = 32;
  localparam int OpW    = 2;
  localparam int PosW   = 8;
  localparam int StatW  = 2;
  localparam int CountW = 5;

  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_GET    = 2'd1;
  localparam logic [OpW-1:0] OP_DELETE = 2'd2;

  localparam logic [StatW-1:0] ST_OK        = 2'd0;
  localparam logic [StatW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatW-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]           opcode;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          position;
  } req_beat_t;

  typedef struct packed {
    logic [StatW-1:0]         status;
    logic signed [ValueW-1:0] result_value;
    logic [CountW-1:0]        entry_count;
    logic                     is_empty;
  } rsp_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_FILL,
    S_GET,
    S_DEL_GET,
    S_DEL_SH,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/stig_ram.sv @@
module stig_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/sorted_table_insert_get_delete_unit.sv @@
// Sorted table of up to CAPACITY signed 32-bit values held in ascending order in one
// single-port-write, registered-read RAM. Insert walks down from the top entry, moving
// each larger entry up one slot, one entry per cycle, and lands after any equal values.
// Inserts into a full table, and gets and deletes at a position beyond the stored
// entries, fail and go straight to the result. Get reads the entry at the position.
// Delete reads the entry, then moves each later entry down one slot per cycle.
// The RAM port is the limit. One operation is in flight at a time and the next
// request is taken in the cycle after the result is loaded; a result beat waits in
// the output register while the next request is taken. Reset gives an empty table
// with no clearing pass.
module sorted_table_insert_get_delete_unit
  import stig_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_beat_t req_data,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_beat_t rsp_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 1;
  localparam int PW = (CW > PosW) ? CW : PosW;

  state_t                   state, state_next;
  logic [CW-1:0]            count, count_next;
  logic [AW-1:0]            ptr, ptr_next;
  logic signed [ValueW-1:0] op_value, op_value_next;
  logic [StatW-1:0]         res_status, res_status_next;
  logic signed [ValueW-1:0] res_value, res_value_next;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ValueW-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [ValueW-1:0] ram_rdata;

  logic          in_range;
  logic [AW-1:0] pos_idx;
  logic          more_after;
  logic          rsp_load;

  stig_ram #(
    .WIDTH(ValueW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign req_stall  = (state != S_IDLE);
  assign in_range   = PW'(req_data.position) < PW'(count);
  assign pos_idx    = req_data.position[AW-1:0];
  assign more_after = (XW'(ptr) + XW'(1)) < XW'(count);
  assign rsp_load   = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    op_value_next   = op_value;
    res_status_next = res_status;
    res_value_next  = res_value;
    ram_we          = 1'b0;
    ram_waddr       = ptr;
    ram_wdata       = ram_rdata;
    ram_raddr       = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_value_next   = req_data.value;
          res_value_next  = '0;
          res_status_next = ST_OK;
          state_next      = S_DONE;
          if (req_data.opcode == OP_INSERT) begin
            if (count == CW'(CAPACITY)) begin
              res_status_next = ST_FULL;
            end else if (count == '0) begin
              ptr_next   = '0;
              state_next = S_INS_FILL;
            end else begin
              ram_raddr  = AW'(count - CW'(1));
              ptr_next   = AW'(count - CW'(1));
              state_next = S_INS;
            end
          end else if (req_data.opcode == OP_GET || req_data.opcode == OP_DELETE) begin
            if (in_range) begin
              ram_raddr  = pos_idx;
              ptr_next   = pos_idx;
              state_next = (req_data.opcode == OP_GET) ? S_GET : S_DEL_GET;
            end else begin
              res_status_next = ST_NOT_FOUND;
            end
          end else begin
            res_status_next = ST_NOT_FOUND;
          end
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = ptr + AW'(1);
        if ($signed(ram_rdata) > op_value) begin
          ram_wdata = ram_rdata;
          if (ptr == '0) begin
            state_next = S_INS_FILL;
          end else begin
            ram_raddr = ptr - AW'(1);
            ptr_next  = ptr - AW'(1);
          end
        end else begin
          ram_wdata  = op_value;
          count_next = count + CW'(1);
          state_next = S_DONE;
        end
      end
      S_INS_FILL: begin
        ram_we     = 1'b1;
        ram_waddr  = ptr;
        ram_wdata  = op_value;
        count_next = count + CW'(1);
        state_next = S_DONE;
      end
      S_GET: begin
        res_value_next = ram_rdata;
        state_next     = S_DONE;
      end
      S_DEL_GET, S_DEL_SH: begin
        if (state == S_DEL_GET) begin
          res_value_next = ram_rdata;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ptr - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (more_after) begin
          ram_raddr  = ptr + AW'(1);
          ptr_next   = ptr + AW'(1);
          state_next = S_DEL_SH;
        end else begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    op_value   <= op_value_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    if (rsp_load) begin
      rsp_data.status       <= res_status;
      rsp_data.result_value <= res_value;
      rsp_data.entry_count  <= CountW'(count);
      rsp_data.is_empty     <= (count == '0);
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_leaves_idle : assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state != S_IDLE))
    else $error("accepted request did not start an operation");

  a_count_moves_at_end : assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (state == S_DONE))
    else $error("entry count changed outside operation end");

  a_ins_ptr_valid : assert property (@(posedge clk) disable iff (rst)
    (state == S_INS) |-> (XW'(ptr) < XW'(count)))
    else $error("insert walk outside stored entries");

endmodule
